/* design/ils_pkg.sv */
// ---------------------------------------------------------------------------
// ils_pkg
// Shared widths, action codes and status codes of the indexed list store.
// ---------------------------------------------------------------------------
package ils_pkg;

   // store geometry
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // field widths
   localparam int ACT_W    = 3;
   localparam int POS_W    = 12;
   localparam int WORD_W   = 32;
   localparam int STAT_W   = 2;
   localparam int LEN_W    = 11;

   // stream data widths, rounded up to whole bytes
   localparam int REQ_DATA_W = ((POS_W + WORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((WORD_W + LEN_W + 7) / 8) * 8;

   // action codes
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SET    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_GET    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // word returned by a get that misses
   localparam logic [WORD_W-1:0] MISS_WORD = 32'h8000_0000;

endpackage

/* design/ils_ram.sv */
// ---------------------------------------------------------------------------
// ils_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write, and register the read data; hold it when no read is issued
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* design/indexed_list_store.sv */
// ---------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed 32-bit words in a single RAM, with clear, append,
// set, get and delete actions and an element count reported on every result.
// ---------------------------------------------------------------------------
//  channel  direction  tdata                         tuser
//  req      in         position, word_in             action
//  rsp      out        word_out, length              status
//
//  Clear, append, set, get, unknown actions and deletes that miss or hit the
//  last slot access the RAM, then load the result register. Other deletes
//  (negative positions resolved from the end) first move later entries down.
//  A result waits in the result register while the next item is accepted;
//  a new result is loaded once the register is empty or being taken.
//  Reset (synchronous) clears the count and control state, not the RAM.
// ---------------------------------------------------------------------------
module indexed_list_store
   import ils_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] position, [43:12] word_in
   input  logic [ACT_W-1:0]      req_tuser,   // [2:0] action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] word_out, [42:32] length
   output logic [STAT_W-1:0]     rsp_tuser    // [1:0] status
);

   typedef enum logic [1:0] {S_IDLE, S_DEL, S_FINISH} state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ADDR_W-1:0]    ptr_ff, ptr_in;
   logic [WORD_W-1:0]    res_word_ff, res_word_in;
   logic [STAT_W-1:0]    res_stat_ff, res_stat_in;
   logic                 res_get_ff, res_get_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_word_ff, rsp_word_in;
   logic [STAT_W-1:0]    rsp_stat_ff, rsp_stat_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;

   logic                 accept;
   logic [ACT_W-1:0]     action;
   logic [POS_W-1:0]     position;
   logic [WORD_W-1:0]    word_in;
   logic signed [POS_W:0] pos_ext, cnt_ext, neg_slot;
   logic                 pos_ok, any_ok;
   logic [ADDR_W-1:0]    slot;
   logic [CNT_W:0]       slot_next, ptr_far, cnt_wide;
   logic                 out_free;

   logic                 ram_we, ram_re;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [WORD_W-1:0]    ram_wdata, ram_rdata;

   ils_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // unpack the request
   assign action   = req_tuser;
   assign position = req_tdata[POS_W-1:0];
   assign word_in  = req_tdata[POS_W+WORD_W-1:POS_W];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // resolve the position against the count, negative from the end
   assign pos_ext   = $signed({position[POS_W-1], position});
   assign cnt_ext   = $signed({{(POS_W + 1 - CNT_W){1'b0}}, count_ff});
   assign neg_slot  = pos_ext + cnt_ext;
   assign pos_ok    = !position[POS_W-1] && (pos_ext < cnt_ext);
   assign any_ok    = pos_ok || (position[POS_W-1] && (neg_slot >= 0));
   assign slot      = position[POS_W-1] ? neg_slot[ADDR_W-1:0] : pos_ext[ADDR_W-1:0];
   assign slot_next = (CNT_W + 1)'(slot) + 1'b1;
   assign ptr_far   = (CNT_W + 1)'(ptr_ff) + 2'd2;
   assign cnt_wide  = (CNT_W + 1)'(count_ff);

   // sequence the RAM accesses and build the result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      res_word_in  = res_word_ff;
      res_stat_in  = res_stat_ff;
      res_get_in   = res_get_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_word_in  = rsp_word_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_len_in   = rsp_len_ff;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = ADDR_W'(ptr_far);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_word_in = '0;
               res_stat_in = ST_DONE;
               res_get_in  = 1'b0;
               state_in    = S_FINISH;
               case (action)
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_APPEND: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        res_stat_in = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = count_ff[ADDR_W-1:0];
                        ram_wdata = word_in;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  ACT_SET: begin
                     if (pos_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = slot;
                        ram_wdata = word_in;
                     end else begin
                        res_stat_in = ST_RANGE;
                     end
                  end
                  ACT_GET: begin
                     if (any_ok) begin
                        ram_re     = 1'b1;
                        ram_raddr  = slot;
                        res_get_in = 1'b1;
                     end else begin
                        res_word_in = MISS_WORD;
                        res_stat_in = ST_RANGE;
                     end
                  end
                  ACT_DELETE: begin
                     if (!any_ok) begin
                        res_stat_in = ST_RANGE;
                     end else if (slot_next < cnt_wide) begin
                        // fetch the first entry to move down
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(slot_next);
                        ptr_in    = slot;
                        state_in  = S_DEL;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DEL: begin
            // move the fetched entry down one place, fetch the next one
            ram_we = 1'b1;
            if (ptr_far < cnt_wide) begin
               ram_re = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // load the result register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_get_ff ? ram_rdata : res_word_ff;
               rsp_stat_in  = res_stat_ff;
               rsp_len_in   = LEN_W'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state, count and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff      <= ptr_in;
      res_word_ff <= res_word_in;
      res_stat_ff <= res_stat_in;
      res_get_ff  <= res_get_in;
      rsp_word_ff <= rsp_word_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_len_ff  <= rsp_len_in;
   end

   // pack the result
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - WORD_W - LEN_W){1'b0}}, rsp_len_ff, rsp_word_ff};
   assign rsp_tuser  = rsp_stat_ff;

`ifndef SYNTHESIS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stat_ff == ST_FULL) |-> rsp_len_ff == LEN_W'(CAPACITY))
      else $error("full status with a count below capacity");

   a_del_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEL) |-> (CNT_W + 1)'(ptr_ff) + 1'b1 < cnt_wide)
      else $error("delete shift beyond the list end");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted item left no work in flight");
`endif

endmodule

/* test/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for indexed_list_store. Items go in on the req stream
// in random bursts while the rsp side stalls on a pattern of its own. A
// behavioral copy of the list predicts each result that a table row does
// not type, and each result is checked field by field. A short table covers
// the edge cases first: empty list, extreme words and positions, unknown
// actions, and a full store. Random traffic follows.
// ---------------------------------------------------------------------------
module testbench;
   import ils_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 800;
   localparam int LONG_HOLD    = 400;
   localparam int SETTLE       = 40;
   localparam int CYCLE_LIMIT  = 1_000_000;

   // action codes the block does not define
   localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

   localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
   localparam logic [WORD_W-1:0] FILL_BASE = 32'h0F0F_0000;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic signed [POS_W-1:0]  position;
      logic signed [WORD_W-1:0] word_in;
   } list_op_t;

   typedef struct packed {
      logic signed [WORD_W-1:0] word_out;
      logic [STAT_W-1:0]        status;
      logic [LEN_W-1:0]         length;
   } list_reply_t;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic signed [POS_W-1:0]  position;
      logic signed [WORD_W-1:0] word_in;
      logic [LEN_W-1:0]         repeats;
      logic                     typed;
      logic signed [WORD_W-1:0] exp_word;
      logic [STAT_W-1:0]        exp_status;
      logic [LEN_W-1:0]         exp_length;
   } edge_row_t;

   localparam int EDGE_ROWS = 29;

   // action, position, word, repeats, typed, expected word, status, length
   edge_row_t edge_rows [EDGE_ROWS] = '{
      '{ACT_GET,     12'sd0,    32'h0,      11'd1,    1'b1, MISS_WORD, ST_RANGE, 11'd0},
      '{ACT_DELETE,  -12'sd1,   32'h0,      11'd1,    1'b1, 32'h0,     ST_RANGE, 11'd0},
      '{ACT_SET,     12'sd0,    32'h5,      11'd1,    1'b1, 32'h0,     ST_RANGE, 11'd0},
      '{ACT_APPEND,  12'sd0,    WORD_MAX,   11'd1,    1'b1, 32'h0,     ST_DONE,  11'd1},
      '{ACT_APPEND,  12'sd0,    WORD_MIN,   11'd1,    1'b1, 32'h0,     ST_DONE,  11'd2},
      '{ACT_GET,     12'sd0,    32'h0,      11'd1,    1'b1, WORD_MAX,  ST_DONE,  11'd2},
      '{ACT_GET,     -12'sd1,   32'h0,      11'd1,    1'b1, WORD_MIN,  ST_DONE,  11'd2},
      '{ACT_GET,     12'sd2,    32'h0,      11'd1,    1'b1, MISS_WORD, ST_RANGE, 11'd2},
      '{ACT_GET,     -12'sd3,   32'h0,      11'd1,    1'b1, MISS_WORD, ST_RANGE, 11'd2},
      '{ACT_SET,     -12'sd1,   32'h1234,   11'd1,    1'b1, 32'h0,     ST_RANGE, 11'd2},
      '{ACT_SET,     12'sd2,    32'h1234,   11'd1,    1'b1, 32'h0,     ST_RANGE, 11'd2},
      '{ACT_SET,     12'sd1,    32'h0,      11'd1,    1'b1, 32'h0,     ST_DONE,  11'd2},
      '{ACT_GET,     12'sd2047, 32'h0,      11'd1,    1'b1, MISS_WORD, ST_RANGE, 11'd2},
      '{ACT_GET,     -12'sd2048, 32'h0,     11'd1,    1'b1, MISS_WORD, ST_RANGE, 11'd2},
      '{ACT_DELETE,  12'sd0,    32'h0,      11'd1,    1'b1, 32'h0,     ST_DONE,  11'd1},
      '{ACT_GET,     12'sd0,    32'h0,      11'd1,    1'b1, 32'h0,     ST_DONE,  11'd1},
      '{ACT_SPARE_5, 12'sd1,    32'hFFFF_FFFF, 11'd1, 1'b1, 32'h0,     ST_DONE,  11'd1},
      '{ACT_SPARE_6, -12'sd1,   32'h1,      11'd1,    1'b1, 32'h0,     ST_DONE,  11'd1},
      '{ACT_SPARE_7, 12'sd0,    32'h2,      11'd1,    1'b1, 32'h0,     ST_DONE,  11'd1},
      '{ACT_CLEAR,   12'sd0,    32'h0,      11'd1,    1'b1, 32'h0,     ST_DONE,  11'd0},
      '{ACT_APPEND,  12'sd0,    FILL_BASE,  11'd1024, 1'b0, 32'h0,     ST_DONE,  11'd0},
      '{ACT_APPEND,  12'sd0,    32'h1,      11'd1,    1'b1, 32'h0,     ST_FULL,  11'd1024},
      '{ACT_GET,     -12'sd1024, 32'h0,     11'd1,    1'b1, FILL_BASE, ST_DONE,  11'd1024},
      '{ACT_GET,     -12'sd1025, 32'h0,     11'd1,    1'b1, MISS_WORD, ST_RANGE, 11'd1024},
      '{ACT_DELETE,  -12'sd1024, 32'h0,     11'd1,    1'b0, 32'h0,     ST_DONE,  11'd0},
      '{ACT_DELETE,  12'sd1023, 32'h0,      11'd1,    1'b1, 32'h0,     ST_RANGE, 11'd1023},
      '{ACT_SET,     12'sd1022, 32'hFFFF_FFFF, 11'd1, 1'b0, 32'h0,     ST_DONE,  11'd0},
      '{ACT_DELETE,  -12'sd1,   32'h0,      11'd1,    1'b0, 32'h0,     ST_DONE,  11'd0},
      '{ACT_CLEAR,   12'sd0,    32'h0,      11'd1,    1'b1, 32'h0,     ST_DONE,  11'd0}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [11:0] position, [43:12] word_in
   logic [ACT_W-1:0]      req_tuser  = '0;   // [2:0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [31:0] word_out, [42:32] length
   logic [STAT_W-1:0]     rsp_tuser;         // [1:0] status

   // behavioral copy of the list
   logic signed [WORD_W-1:0] list_words [CAPACITY];
   int                       list_count = 0;

   list_reply_t pending_replies [$];
   list_reply_t next_reply;
   int          error_count    = 0;
   int          replies_seen   = 0;
   int          burst_left     = 0;
   bit          long_hold_done = 1'b0;

   indexed_list_store u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Apply one action to the list copy and return the result it should give.
   function automatic list_reply_t apply_list_op(input list_op_t op);
      list_reply_t reply;
      int          pos;
      int          slot;
      int          i;
      bit          hit;
      reply = '0;
      reply.status = ST_DONE;
      pos = int'(op.position);
      hit = 1'b0;
      slot = 0;
      // resolve the position; negative counts back from the end
      if (pos >= 0 && pos < list_count) begin
         hit = 1'b1;
         slot = pos;
      end else if (pos < 0 && pos + list_count >= 0) begin
         hit = 1'b1;
         slot = pos + list_count;
      end
      case (op.action)
         ACT_CLEAR: begin
            list_count = 0;
         end
         ACT_APPEND: begin
            if (list_count >= CAPACITY) begin
               reply.status = ST_FULL;
            end else begin
               list_words[list_count] = op.word_in;
               list_count++;
            end
         end
         ACT_SET: begin
            // set takes no negative position
            if (hit && pos >= 0) begin
               list_words[slot] = op.word_in;
            end else begin
               reply.status = ST_RANGE;
            end
         end
         ACT_GET: begin
            if (hit) begin
               reply.word_out = list_words[slot];
            end else begin
               reply.word_out = MISS_WORD;
               reply.status = ST_RANGE;
            end
         end
         ACT_DELETE: begin
            if (hit) begin
               for (i = slot; i + 1 < list_count; i++) begin
                  list_words[i] = list_words[i + 1];
               end
               list_count--;
            end else begin
               reply.status = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
      reply.length = LEN_W'(list_count);
      return reply;
   endfunction

   // Offer one item and hold it until accepted, then idle between bursts.
   task automatic offer_item(input list_op_t op, input bit use_typed,
                             input list_reply_t typed_reply);
      list_reply_t predicted;
      int          gap;
      @(negedge clock);
      predicted = apply_list_op(op);
      next_reply = use_typed ? typed_reply : predicted;
      req_tvalid <= 1'b1;
      req_tuser <= op.action;
      req_tdata <= REQ_DATA_W'({op.word_in, op.position});
      do @(posedge clock); while (!req_tready);
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         burst_left = $urandom_range(1, 24);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // Stop offering until every outstanding result has come back.
   task automatic drain_replies();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
   endtask

   // Check each result against the oldest expectation; queue accepted items.
   always @(posedge clock) begin : reply_check
      list_reply_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
               $error("result with no item outstanding");
               error_count++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_tdata[WORD_W-1:0] !== want.word_out) begin
                  $error("word_out: expected %h, got %h", want.word_out,
                         rsp_tdata[WORD_W-1:0]);
                  error_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[WORD_W +: LEN_W] !== want.length) begin
                  $error("length: expected %0d, got %0d", want.length,
                         rsp_tdata[WORD_W +: LEN_W]);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_replies.push_back(next_reply);
         end
      end
   end

   // Stall the result side in spans of varying density, with one long hold.
   initial begin : result_stall
      int mode;
      int span;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(negedge clock);
            if (!long_hold_done && replies_seen >= 120) begin
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD) @(negedge clock);
               long_hold_done = 1'b1;
            end
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // End the run if it hangs.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      list_op_t    op;
      list_reply_t typed_reply;
      int          row;
      int          k;
      int          item_idx;
      int          target;
      int          pick;
      int          idx;
      bit          grow;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // edge cases from the table
      for (row = 0; row < EDGE_ROWS; row++) begin
         for (k = 0; k < int'(edge_rows[row].repeats); k++) begin
            op.action = edge_rows[row].action;
            op.position = edge_rows[row].position;
            op.word_in = edge_rows[row].word_in + WORD_W'(k);
            typed_reply.word_out = edge_rows[row].exp_word;
            typed_reply.status = edge_rows[row].exp_status;
            typed_reply.length = edge_rows[row].exp_length;
            offer_item(op, edge_rows[row].typed, typed_reply);
         end
      end
      drain_replies();

      // random traffic; the list size drifts toward a target that moves
      target = 0;
      for (item_idx = 0; item_idx < RANDOM_ITEMS; item_idx++) begin
         if (item_idx % 50 == 0) begin
            target = ($urandom_range(0, 4) == 0) ? int'($urandom_range(40, 400))
                                                 : int'($urandom_range(0, 40));
         end
         if (item_idx == RANDOM_ITEMS / 2) begin
            drain_replies();
         end
         grow = (list_count < target);
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            op.action = ACT_CLEAR;
         end else if (pick < 5) begin
            case ($urandom_range(0, 2))
               0: op.action = ACT_SPARE_5;
               1: op.action = ACT_SPARE_6;
               default: op.action = ACT_SPARE_7;
            endcase
         end else if (pick < (grow ? 50 : 18)) begin
            op.action = ACT_APPEND;
         end else if (pick < (grow ? 65 : 33)) begin
            op.action = ACT_SET;
         end else if (pick < (grow ? 87 : 55)) begin
            op.action = ACT_GET;
         end else begin
            op.action = ACT_DELETE;
         end
         op.word_in = $urandom;
         // mostly valid positions, some at the border, some anywhere
         pick = $urandom_range(0, 99);
         if (pick < 70 && list_count > 0) begin
            idx = $urandom_range(0, list_count - 1);
            if ($urandom_range(0, 2) == 0) begin
               op.position = POS_W'(idx - list_count);
            end else begin
               op.position = POS_W'(idx);
            end
         end else if (pick < 85) begin
            case ($urandom_range(0, 3))
               0: op.position = POS_W'(list_count);
               1: op.position = POS_W'(-list_count - 1);
               2: op.position = '0;
               default: op.position = '1;
            endcase
         end else begin
            op.position = POS_W'($urandom);
         end
         offer_item(op, 1'b0, '0);
      end

      // let the last results come back, then idle for SETTLE and check none are left
      drain_replies();
      repeat (SETTLE) @(negedge clock);
      if (pending_replies.size() != 0) begin
         $error("%0d results never arrived", pending_replies.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
